>>> hdl/assert_macros.svh
// Assertion macros shared by the binner RTL.
// Needs a clock named clk and a synchronous reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ptpsb_pkg.sv
// Package for the polar scan binner: widths, codes, config/result types, atan table.
// No dependencies.
`default_nettype none

package ptpsb_pkg;

  localparam int BINS         = 1080;
  localparam int BIN_W        = $clog2(BINS);
  localparam int MAX_DIM      = 1024;
  localparam int DIM_W        = $clog2(MAX_DIM);
  localparam int CFG_DIM_W    = DIM_W + 1;
  localparam int DIFF_W       = DIM_W + 2;
  localparam int PIX_W        = 8;
  localparam int MPP_W        = 16;
  localparam int OFF_W        = 16;
  localparam int OFF_SHIFT    = 8;
  localparam int RANGE_W      = 24;
  localparam int RANGE_SAT    = 2 ** RANGE_W - 1;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int ATAN_LEN     = 24;
  localparam int CW           = 32;
  localparam int MUL_BW       = 33;
  localparam int PROD_W       = CW + MUL_BW;
  localparam int PI_SHIFT     = 31;
  localparam int HALF_PI      = 2 ** (PI_SHIFT - 1);
  localparam int RANGE_SHIFT  = 40;
  localparam int RQ_W         = PROD_W - RANGE_SHIFT;
  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

  localparam logic [CFG_DIM_W-1:0] ROWS_RESET   = CFG_DIM_W'(1000);
  localparam logic [CFG_DIM_W-1:0] COLS_RESET   = CFG_DIM_W'(800);
  localparam logic [MPP_W-1:0]     MPP_RESET    = MPP_W'(655);
  localparam logic [OFF_W-1:0]     OFFSET_RESET = OFF_W'(0);

  localparam logic signed [CW-1:0] ATAN_TABLE [ATAN_LEN] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS   = 2'd0,
    REG_COLS   = 2'd1,
    REG_MPP    = 2'd2,
    REG_OFFSET = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] rows;
    logic [CFG_DIM_W-1:0] cols;
    logic [MPP_W-1:0]     mpp;
    logic [OFF_W-1:0]     offset;
  } cfg_t;

  typedef struct packed {
    logic               hit;
    logic [BIN_W-1:0]   bin;
    logic [RANGE_W-1:0] rng;
  } pix_res_t;

  function automatic logic signed [CW-1:0] atan_at(input logic [STEP_W-1:0] i);
    return ATAN_TABLE[i];
  endfunction

endpackage

`default_nettype wire

>>> hdl/ptpsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ptpsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/ptpsb_cordic.sv
// Iterative pixel-to-polar unit: shared multiplier plus a shift-add CORDIC stage.
// Depends on ptpsb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ptpsb_cordic (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  ptpsb_pkg::cfg_t             cfg,
  input  logic [ptpsb_pkg::DIM_W-1:0] row,
  input  logic [ptpsb_pkg::DIM_W-1:0] col,
  output logic                        done,
  output ptpsb_pkg::pix_res_t         res
);
  import ptpsb_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL_A  = 9'b000000010,
    S_MUL_B  = 9'b000000100,
    S_CHECK  = 9'b000001000,
    S_ROTATE = 9'b000010000,
    S_ANGLE  = 9'b000100000,
    S_BIN    = 9'b001000000,
    S_SCALE  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [STEP_W-1:0]      step;
  logic signed [CW-1:0]   x, y, z;
  logic [PI_SHIFT-1:0]    t;
  logic                   hit;
  logic [BIN_W-1:0]       bin;
  logic [RANGE_W-1:0]     rng;

  logic signed [DIFF_W-1:0] diff_a, diff_b;
  logic signed [CW-1:0]     mul_a, off_ext, x_clamp;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;

  logic signed [CW-1:0]   xs, ys, x_next, y_next, z_next;
  logic                   y_pos, x_gt0, last_step;
  logic signed [CW:0]     tt;
  logic [PI_SHIFT-1:0]    t_clamp;
  logic [BIN_W:0]         kraw, kc;
  logic [RQ_W-1:0]        rq;

  assign diff_a  = DIFF_W'({2'b00, cfg.cols[CFG_DIM_W-1:1]}) - DIFF_W'({2'b00, col});
  assign diff_b  = DIFF_W'({1'b0, cfg.rows}) - DIFF_W'({2'b00, row});
  assign off_ext = CW'({cfg.offset, {OFF_SHIFT{1'b0}}});
  assign x_clamp = x[CW-1] ? '0 : x;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MUL_A: begin
        mul_a = CW'(diff_a);
        mul_b = MUL_BW'({1'b0, cfg.mpp});
      end
      S_MUL_B: begin
        mul_a = CW'(diff_b);
        mul_b = MUL_BW'({1'b0, cfg.mpp});
      end
      S_BIN: begin
        mul_a = CW'({1'b0, t});
        mul_b = MUL_BW'(BINS);
      end
      S_SCALE: begin
        mul_a = x_clamp;
        mul_b = MUL_BW'(GAIN_Q32);
      end
      default: begin
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // one CORDIC vectoring step
  assign xs        = x >>> step;
  assign ys        = y >>> step;
  assign y_pos     = !y[CW-1] && (y != '0);
  assign x_next    = y_pos ? x + ys : x - ys;
  assign y_next    = y_pos ? y - xs : y + xs;
  assign z_next    = y_pos ? z + atan_at(step) : z - atan_at(step);
  assign x_gt0     = !x[CW-1] && (x != '0);
  assign last_step = (step == STEP_W'(CORDIC_STEPS - 1));

  // shift angle to 0..pi and clamp
  assign tt = (CW+1)'({z[CW-1], z}) + (CW+1)'(HALF_PI);
  always_comb begin
    if (tt[CW]) begin
      t_clamp = '0;
    end else if (|tt[CW-1:PI_SHIFT]) begin
      t_clamp = '1;
    end else begin
      t_clamp = tt[PI_SHIFT-1:0];
    end
  end

  assign kraw = prod[PI_SHIFT +: BIN_W+1];
  assign kc   = (kraw > (BIN_W+1)'(BINS - 1)) ? (BIN_W+1)'(BINS - 1) : kraw;
  assign rq   = prod[RANGE_SHIFT +: RQ_W];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_MUL_A;
      S_MUL_A:  state_next = S_MUL_B;
      S_MUL_B:  state_next = S_CHECK;
      S_CHECK:  state_next = x_gt0 ? S_ROTATE : S_DONE;
      S_ROTATE: if (last_step) state_next = S_ANGLE;
      S_ANGLE:  state_next = S_BIN;
      S_BIN:    state_next = S_SCALE;
      S_SCALE:  state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_MUL_A: begin
        y <= prod[CW-1:0];
      end
      S_MUL_B: begin
        x <= prod[CW-1:0] + off_ext;
        z <= '0;
      end
      S_CHECK: begin
        step <= '0;
        hit  <= x_gt0;
        bin  <= '0;
        rng  <= '0;
      end
      S_ROTATE: begin
        x    <= x_next;
        y    <= y_next;
        z    <= z_next;
        step <= step + STEP_W'(1);
      end
      S_ANGLE: begin
        t <= t_clamp;
      end
      S_BIN: begin
        bin <= BIN_W'((BIN_W+1)'(BINS - 1) - kc);
      end
      S_SCALE: begin
        rng <= (rq > RQ_W'(RANGE_SAT)) ? RANGE_W'(RANGE_SAT) : rq[RANGE_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign done = (state == S_DONE);
  assign res  = '{hit: hit, bin: bin, rng: rng};

  `ASSERT_CLK(a_start_idle, start |-> state == S_IDLE, "start while busy")
  `ASSERT_CLK(a_done_pulse, done |=> !done, "done longer than one cycle")
  `ASSERT_CLK(a_bin_in_range, done && res.hit |-> (BIN_W+1)'(res.bin) < (BIN_W+1)'(BINS), "bad bin")

endmodule

`default_nettype wire

>>> hdl/pixel_to_polar_scan_binner.sv
// Polar scan binner. A lit pixel's result comes from the 16-step CORDIC loop on the
// shift-add stage; dark pixels skip to T_FINISH, reads pass T_READ, clears T_CLEAR.
// One item at a time: the next beat is taken the cycle after the result is loaded.
// Reset: synchronous; a clearing pass over all BINS (1080) entries follows, item_stall high.
// Depends on ptpsb_pkg, ptpsb_cordic, ptpsb_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pixel_to_polar_scan_binner (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [1:0]                       operation,
  input  logic [ptpsb_pkg::PIX_W-1:0]      pixel_value,
  input  logic [ptpsb_pkg::DIM_W-1:0]      row_index,
  input  logic [ptpsb_pkg::DIM_W-1:0]      col_index,
  input  logic [ptpsb_pkg::BIN_W-1:0]      bin_select,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [ptpsb_pkg::BIN_W-1:0]      bin_index,
  output logic [ptpsb_pkg::RANGE_W-1:0]    range_q8,
  output logic                             bin_empty,
  output logic                             pixel_hit,
  input  logic                             cfg_we,
  input  logic [ptpsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptpsb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ptpsb_pkg::*;

  typedef enum logic [4:0] {
    T_CLEAR  = 5'b00001,
    T_IDLE   = 5'b00010,
    T_PIXEL  = 5'b00100,
    T_READ   = 5'b01000,
    T_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  cfg_t               cfg;
  logic [BIN_W-1:0]   clr_addr;
  logic               clr_report, clr_last;
  logic               accept, lit, out_free, dp_start, dp_done;
  pix_res_t           dp_res;
  logic [DIM_W-1:0]   row_r, col_r;
  logic               sel_ok, entry_ok;
  logic [BIN_W-1:0]   p_bin;
  logic [RANGE_W-1:0] p_rng;
  logic               p_empty, p_hit;
  logic               result_valid_next;

  logic               ram_we;
  logic [BIN_W-1:0]   ram_waddr;
  logic [RANGE_W:0]   ram_wdata, ram_rdata;

  assign item_stall = (state != T_IDLE);
  assign accept     = item_valid && !item_stall;
  assign lit        = (pixel_value != '0);
  assign out_free   = !result_valid || !result_stall;
  assign dp_start   = accept && (operation == OP_PIXEL) && lit;
  assign clr_last   = (clr_addr == BIN_W'(BINS - 1));
  assign entry_ok   = sel_ok && ram_rdata[RANGE_W];

  ptpsb_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (dp_start),
    .cfg   (cfg),
    .row   (row_r),
    .col   (col_r),
    .done  (dp_done),
    .res   (dp_res)
  );

  // entry: {valid, range}
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dp_res.bin;
    ram_wdata = {1'b1, dp_res.rng};
    if (state == T_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == T_PIXEL && dp_done && dp_res.hit) begin
      ram_we = 1'b1;
    end
  end

  ptpsb_ram #(
    .WIDTH (RANGE_W + 1),
    .DEPTH (BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (bin_select),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      T_CLEAR: if (clr_last) state_next = clr_report ? T_FINISH : T_IDLE;
      T_IDLE: begin
        if (accept) begin
          unique case (operation)
            OP_PIXEL: state_next = lit ? T_PIXEL : T_FINISH;
            OP_READ:  state_next = T_READ;
            OP_CLEAR: state_next = T_CLEAR;
            default:  state_next = T_FINISH;
          endcase
        end
      end
      T_PIXEL:  if (dp_done) state_next = T_FINISH;
      T_READ:   state_next = T_FINISH;
      T_FINISH: if (out_free) state_next = T_IDLE;
      default:  state_next = T_IDLE;
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (state == T_FINISH && out_free) begin
      result_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_CLEAR;
      clr_addr     <= '0;
      clr_report   <= 1'b0;
      result_valid <= 1'b0;
      cfg.rows     <= ROWS_RESET;
      cfg.cols     <= COLS_RESET;
      cfg.mpp      <= MPP_RESET;
      cfg.offset   <= OFFSET_RESET;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
      if (state == T_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + BIN_W'(1);
      end
      if (accept && operation == OP_CLEAR) begin
        clr_report <= 1'b1;
      end else if (state == T_CLEAR && clr_last) begin
        clr_report <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS:   cfg.rows   <= cfg_data[CFG_DIM_W-1:0];
          REG_COLS:   cfg.cols   <= cfg_data[CFG_DIM_W-1:0];
          REG_MPP:    cfg.mpp    <= cfg_data[MPP_W-1:0];
          REG_OFFSET: cfg.offset <= cfg_data[OFF_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_r   <= row_index;
      col_r   <= col_index;
      sel_ok  <= ((BIN_W+1)'(bin_select) < (BIN_W+1)'(BINS));
      p_bin   <= (operation == OP_READ) ? bin_select : '0;
      p_rng   <= '0;
      p_empty <= 1'b0;
      p_hit   <= 1'b0;
    end
    if (state == T_READ) begin
      p_rng   <= entry_ok ? ram_rdata[RANGE_W-1:0] : '0;
      p_empty <= !entry_ok;
    end
    if (state == T_PIXEL && dp_done) begin
      p_bin <= dp_res.bin;
      p_rng <= dp_res.rng;
      p_hit <= dp_res.hit;
    end
    if (state == T_FINISH && out_free) begin
      bin_index <= p_bin;
      range_q8  <= p_rng;
      bin_empty <= p_empty;
      pixel_hit <= p_hit;
    end
  end

  `ASSERT_RST(a_reset_clears, rst |=> state == T_CLEAR && !result_valid, "no clear after reset")
  `ASSERT_CLK(a_accept_stalls, accept |=> item_stall, "second beat taken while busy")
  `ASSERT_CLK(a_done_in_pixel, dp_done |-> state == T_PIXEL, "cordic done outside pixel work")
  `ASSERT_CLK(a_empty_result, result_valid && bin_empty |-> range_q8 == '0 && !pixel_hit, "empty bin data")

endmodule

`default_nettype wire

>>> tb/pixel_to_polar_scan_binner_tb.sv
// Self-checking testbench for pixel_to_polar_scan_binner: directed and random pixel,
// read and clear beats checked against a built-in polar binning predictor.
// Depends on ptpsb_pkg and the binner RTL.
`timescale 1ns / 100ps

module pixel_to_polar_scan_binner_tb;
  import ptpsb_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    logic [1:0]         op;
    logic [PIX_W-1:0]   pix;
    logic [DIM_W-1:0]   row;
    logic [DIM_W-1:0]   col;
    logic [BIN_W-1:0]   sel;
  } scan_request_t;

  typedef struct packed {
    logic [BIN_W-1:0]   bin;
    logic [RANGE_W-1:0] rng;
    logic               empty;
    logic               hit;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] operation = '0;
  logic [PIX_W-1:0] pixel_value = '0;
  logic [DIM_W-1:0] row_index = '0;
  logic [DIM_W-1:0] col_index = '0;
  logic [BIN_W-1:0] bin_select = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [BIN_W-1:0] bin_index;
  logic [RANGE_W-1:0] range_q8;
  logic bin_empty;
  logic pixel_hit;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pixel_to_polar_scan_binner dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .operation(operation), .pixel_value(pixel_value), .row_index(row_index),
    .col_index(col_index), .bin_select(bin_select),
    .result_valid(result_valid), .result_stall(result_stall),
    .bin_index(bin_index), .range_q8(range_q8), .bin_empty(bin_empty),
    .pixel_hit(pixel_hit),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // frame geometry as the block should hold it
  logic [CFG_DIM_W-1:0] frame_rows = 1000;
  logic [CFG_DIM_W-1:0] frame_cols = 800;
  logic [MPP_W-1:0]     frame_mpp = 655;
  logic [OFF_W-1:0]     frame_offset = 0;

  logic [RANGE_W-1:0] scan_range [BINS];
  bit                 scan_filled [BINS];

  longint arc_table [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  scan_request_t queued_requests [$];
  scan_result_t  awaited_scan_results [$];
  logic [BIN_W-1:0] aim_bins [$];

  scan_request_t cur_req;
  bit presenting = 0;
  bit beat_taken = 0;
  bit result_taken = 0;
  int src_wait = 0;
  int snk_wait = 0;
  int src_gap_max = 8;
  int snk_gap_max = 8;
  int hold_asks = 0;
  int hold_done = 0;
  int hold_left = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  // CORDIC vectoring of (forward, lateral), angle binned and mirrored
  function automatic void locate_point(input logic [DIM_W-1:0] row, input logic [DIM_W-1:0] col,
                                       output bit ahead, output logic [BIN_W-1:0] bin,
                                       output logic [RANGE_W-1:0] rng);
    longint lat, fwd, x, y, z, xs, ys, t, k;
    longint unsigned xu, r;
    int i;
    lat = (longint'(frame_cols >> 1) - longint'(col)) * longint'(frame_mpp);
    fwd = (longint'(frame_rows) - longint'(row)) * longint'(frame_mpp)
        + (longint'(frame_offset) <<< 8);
    ahead = fwd > 0;
    bin = '0;
    rng = '0;
    if (!ahead) return;
    x = fwd;
    y = lat;
    z = 0;
    for (i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + arc_table[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - arc_table[i];
      end
    end
    t = z + 64'sd1073741824;
    if (t < 0) t = 0;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    k = (t * BINS) >>> 31;
    if (k > BINS - 1) k = BINS - 1;
    k = BINS - 1 - k;
    if (x < 0) x = 0;
    xu = x;
    r = (xu * 64'd2608131496) >> 40;
    if (r > 64'hFFFFFF) r = 64'hFFFFFF;
    bin = BIN_W'(k);
    rng = RANGE_W'(r);
  endfunction

  function automatic logic [BIN_W-1:0] lit_bin(input int row, input int col);
    bit ahead;
    logic [BIN_W-1:0] bin;
    logic [RANGE_W-1:0] rng;
    locate_point(DIM_W'(row), DIM_W'(col), ahead, bin, rng);
    return bin;
  endfunction

  function automatic scan_result_t apply_scan_request(input scan_request_t rq);
    scan_result_t res;
    bit ahead;
    logic [BIN_W-1:0] bin;
    logic [RANGE_W-1:0] rng;
    res = '0;
    case (rq.op)
      OP_PIXEL: begin
        if (rq.pix != 0) begin
          locate_point(rq.row, rq.col, ahead, bin, rng);
          if (ahead) begin
            scan_range[bin] = rng;
            scan_filled[bin] = 1;
            res.bin = bin;
            res.rng = rng;
            res.hit = 1'b1;
          end
        end
      end
      OP_READ: begin
        res.bin = rq.sel;
        if (rq.sel < BINS && scan_filled[rq.sel]) res.rng = scan_range[rq.sel];
        else res.empty = 1'b1;
      end
      OP_CLEAR: begin
        foreach (scan_filled[i]) scan_filled[i] = 0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // sender
  always @(posedge clk) begin
    if (item_valid && !item_stall) begin
      awaited_scan_results.insert(awaited_scan_results.size(), apply_scan_request(cur_req));
      beat_taken = 1;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (beat_taken) begin
        beat_taken = 0;
        presenting = 0;
        src_wait = $urandom_range(0, src_gap_max);
      end
      if (!presenting) begin
        if (src_wait > 0) begin
          src_wait--;
        end else if (queued_requests.size() > 0) begin
          cur_req = queued_requests.pop_front();
          presenting = 1;
          operation <= cur_req.op;
          pixel_value <= cur_req.pix;
          row_index <= cur_req.row;
          col_index <= cur_req.col;
          bin_select <= cur_req.sel;
        end
      end
      item_valid <= presenting;
    end
  end

  // receiver
  always @(posedge clk) begin
    scan_result_t want;
    if (result_valid && !result_stall) begin
      result_taken = 1;
      if (awaited_scan_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: bin %0d range %0d empty %0b hit %0b",
                   bin_index, range_q8, bin_empty, pixel_hit);
      end else begin
        want = awaited_scan_results.pop_front();
        if (bin_index !== want.bin || range_q8 !== want.rng ||
            bin_empty !== want.empty || pixel_hit !== want.hit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected bin %0d range %0d empty %0b hit %0b, got %0d %0d %0b %0b",
                     want.bin, want.rng, want.empty, want.hit,
                     bin_index, range_q8, bin_empty, pixel_hit);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_asks != hold_done) begin
      hold_done = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (result_taken) begin
      result_taken = 0;
      snk_wait = $urandom_range(0, snk_gap_max);
    end
    result_stall <= (hold_left > 0) || (snk_wait > 0);
    if (hold_left > 0) hold_left--;
    else if (snk_wait > 0) snk_wait--;
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROWS:   frame_rows = CFG_DIM_W'(val);
      REG_COLS:   frame_cols = CFG_DIM_W'(val);
      REG_MPP:    frame_mpp = MPP_W'(val);
      REG_OFFSET: frame_offset = OFF_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_frame(input int rows, input int cols, input int mpp, input int offset);
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
    write_reg(REG_MPP, mpp);
    write_reg(REG_OFFSET, offset);
  endtask

  task automatic queue_request(input logic [1:0] op, input int pix, input int row,
                               input int col, input int sel);
    scan_request_t rq;
    rq.op = op;
    rq.pix = PIX_W'(pix);
    rq.row = DIM_W'(row);
    rq.col = DIM_W'(col);
    rq.sel = BIN_W'(sel);
    queued_requests.insert(queued_requests.size(), rq);
  endtask

  task automatic wait_idle();
    while (queued_requests.size() > 0 || presenting || awaited_scan_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic make_random_request(output scan_request_t rq);
    int roll;
    bit ahead;
    logic [BIN_W-1:0] bin;
    logic [RANGE_W-1:0] rng;
    rq.op = 2'($urandom_range(0, 3));
    rq.pix = PIX_W'($urandom);
    rq.row = DIM_W'($urandom);
    rq.col = DIM_W'($urandom);
    rq.sel = BIN_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      rq.op = OP_PIXEL;
      if ($urandom_range(0, 9) == 0) rq.pix = '0;
      else rq.pix = PIX_W'($urandom_range(1, 255));
      if ($urandom_range(0, 6) != 0) begin
        rq.row = DIM_W'($urandom_range(0, int'(frame_rows) - 1));
        rq.col = DIM_W'($urandom_range(0, int'(frame_cols) - 1));
      end
      locate_point(rq.row, rq.col, ahead, bin, rng);
      if (rq.pix != 0 && ahead) begin
        aim_bins.insert(aim_bins.size(), bin);
        if (aim_bins.size() > 32) void'(aim_bins.pop_front());
      end
    end else if (roll < 85) begin
      rq.op = OP_READ;
      if (aim_bins.size() > 0 && $urandom_range(0, 9) < 7)
        rq.sel = aim_bins[$urandom_range(0, aim_bins.size() - 1)];
    end else if (roll < 88) begin
      rq.op = OP_CLEAR;
    end else if (roll < 91) begin
      rq.op = OP_UNUSED;
    end
  endtask

  initial begin
    scan_request_t rq;
    int p;
    foreach (scan_filled[i]) scan_filled[i] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed beats at the reset geometry
    queue_request(OP_READ, 0, 0, 0, 0);
    queue_request(OP_READ, 0, 0, 0, BINS - 1);
    queue_request(OP_READ, 0, 0, 0, BINS);
    queue_request(OP_READ, 255, 1023, 1023, 2047);
    queue_request(OP_PIXEL, 0, 500, 400, 0);
    queue_request(OP_PIXEL, 255, 0, 400, 0);
    queue_request(OP_PIXEL, 1, 999, 0, 0);
    queue_request(OP_PIXEL, 128, 999, 1023, 0);
    queue_request(OP_PIXEL, 7, 1000, 10, 0);
    queue_request(OP_PIXEL, 9, 1023, 1023, 0);
    queue_request(OP_PIXEL, 20, 800, 300, 0);
    queue_request(OP_PIXEL, 30, 600, 200, 0);
    queue_request(OP_READ, 0, 0, 0, lit_bin(0, 400));
    queue_request(OP_READ, 0, 0, 0, lit_bin(999, 0));
    queue_request(OP_READ, 0, 0, 0, lit_bin(600, 200));
    queue_request(OP_UNUSED, 255, 1023, 1023, 2047);
    queue_request(OP_READ, 0, 0, 0, lit_bin(0, 400));
    queue_request(OP_CLEAR, 0, 0, 0, 0);
    queue_request(OP_READ, 0, 0, 0, lit_bin(0, 400));
    queue_request(OP_READ, 0, 0, 0, lit_bin(999, 0));
    queue_request(OP_PIXEL, 255, 0, 0, 0);
    queue_request(OP_PIXEL, 200, 0, 1023, 0);
    queue_request(OP_READ, 0, 0, 0, lit_bin(0, 0));
    queue_request(OP_READ, 0, 0, 0, lit_bin(0, 1023));

    for (p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: set_frame(1024, 1024, 65535, 65535);
        1: set_frame(1, 1, 1, 0);
        2: set_frame(480, 640, 1000, 300);
        3: set_frame(1000, 800, 655, 0);
        default: set_frame($urandom_range(1, 1024), $urandom_range(1, 1024),
                           $urandom_range(1, 65535), $urandom_range(0, 65535));
      endcase
      src_gap_max = (p == 3 || p == 5) ? 0 : 8;
      snk_gap_max = (p == 3 || p == 6) ? 0 : 8;
      aim_bins.delete();
      if (p == 2) hold_asks++;
      repeat (PHASE_ITEMS) begin
        make_random_request(rq);
        queued_requests.insert(queued_requests.size(), rq);
      end
    end

    wait_idle();
    if (mismatches == 0 && awaited_scan_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> pixel_to_polar_scan_binner.f
+incdir+hdl
hdl/ptpsb_pkg.sv
hdl/ptpsb_ram.sv
hdl/ptpsb_cordic.sv
hdl/pixel_to_polar_scan_binner.sv
tb/pixel_to_polar_scan_binner_tb.sv
